// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of i_clk while reset is released.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge of i_clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== sv/tops_pkg.sv =====
`timescale 1ns / 1ps

package tops_pkg;

    // Command codes carried on the input tuser.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_MANUAL = 2'd2;

    // Configuration register indexes.
    localparam logic REG_UNIT_NUMBER = 1'b0;

    localparam int STEP_TIME_W = 13;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    typedef logic [STEP_TIME_W-1:0] t_step_time;

    typedef struct packed {
        t_step_time ms;
        logic       level;
    } t_step;

    // One result item, as it leaves the block.
    typedef struct packed {
        logic [4:0] step_index;
        logic [1:0] pattern_number;
        logic       playing;
        logic       output_level;
    } t_result;

    localparam logic [4:0] STEP_COUNTS [4] = '{5'd8, 5'd25, 5'd18, 5'd12};

    localparam t_step_time FIRST_TIMES [8] = '{
        13'd0, 13'd100, 13'd500, 13'd1000, 13'd2000, 13'd2500, 13'd3500, 13'd5000
    };

    localparam logic [1:0] FOURTH_OFFSETS [4] = '{2'd0, 2'd3, 2'd1, 2'd2};

    function automatic logic [4:0] step_count(input logic [1:0] pat);
        return STEP_COUNTS[pat];
    endfunction

    function automatic t_step_time fourth_time(input logic [3:0] k);
        t_step_time ms;
        unique case (k)
            4'd0:    ms = 13'd0;
            4'd1:    ms = 13'd100;
            4'd2:    ms = 13'd500;
            4'd3:    ms = 13'd600;
            4'd4:    ms = 13'd1100;
            4'd5:    ms = 13'd1200;
            4'd6:    ms = 13'd1700;
            4'd7:    ms = 13'd1800;
            4'd8:    ms = 13'd2300;
            default: ms = 13'd2400;
        endcase
        return ms;
    endfunction

    // Start time and level of step k of pattern pat for the given unit number.
    function automatic t_step step_info(input logic [1:0] pat, input logic [4:0] k,
                                        input logic [1:0] unit);
        t_step      s;
        logic [5:0] k_plus_u;
        k_plus_u = {1'b0, k} + {4'b0, unit};
        unique case (pat)
            2'd0: begin
                s.ms    = FIRST_TIMES[k[2:0]];
                s.level = ~k[0];
            end
            2'd1: begin
                s.ms    = (k == 5'd0) ? '0 : {7'b0, k_plus_u} * 13'd100;
                s.level = k[0];
            end
            2'd2: begin
                if (k >= 5'd17) begin
                    s.ms    = 13'd4000;
                    s.level = 1'b0;
                end else begin
                    s.ms = {8'b0, k} * 13'd200;
                    if (k >= 5'd15) begin
                        s.level = 1'b1;
                    end else if (unit < 2'd2) begin
                        s.level = k[0];
                    end else begin
                        s.level = ~k[0];
                    end
                end
            end
            default: begin
                if (k >= 5'd11) begin
                    s.ms    = 13'd4500;
                    s.level = 1'b0;
                end else if (k == 5'd10) begin
                    s.ms    = 13'd3000;
                    s.level = 1'b1;
                end else begin
                    s.ms    = fourth_time(k[3:0])
                            + {11'b0, FOURTH_OFFSETS[unit]} * 13'd100;
                    s.level = ~k[0];
                end
            end
        endcase
        return s;
    endfunction

endpackage

// ===== sv/tops_engine.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tops_engine
    import tops_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [1:0] i_cmd,
    input  logic [31:0] i_now_ms,
    input  logic [2:0] i_tgt,
    input  logic       i_lvl,
    input  logic [1:0] i_unit,
    output t_result    o_result
);

    logic                  r_running;
    logic [1:0]            r_active;
    logic [4:0]            r_next_step;
    logic [TIME_WIDTH-1:0] r_start;
    logic                  r_drive;

    logic                  n_running;
    logic [1:0]            n_active;
    logic [4:0]            n_next_step;
    logic [TIME_WIDTH-1:0] n_start;
    logic                  n_drive;

    logic [TIME_WIDTH-1:0] now_t;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  is_start;
    logic [1:0]            info_pat;
    logic [4:0]            info_step;
    t_step                 info;

    assign now_t     = TIME_WIDTH'(i_now_ms);
    assign elapsed   = now_t - r_start;
    assign is_start  = (i_cmd == CMD_START);
    // Start looks up step 0 of the requested pattern, a tick the pending step.
    assign info_pat  = is_start ? i_tgt[1:0] : r_active;
    assign info_step = is_start ? 5'd0 : r_next_step;
    assign info      = step_info(info_pat, info_step, i_unit);

    always_comb begin
        n_running   = r_running;
        n_active    = r_active;
        n_next_step = r_next_step;
        n_start     = r_start;
        n_drive     = r_drive;
        if (i_accept) begin
            unique case (i_cmd)
                CMD_TICK: begin
                    if (r_running) begin
                        if (r_next_step >= step_count(r_active)) begin
                            n_running = 1'b0;
                            n_drive   = 1'b0;
                        end else if (elapsed >= TIME_WIDTH'(info.ms)) begin
                            n_drive     = info.level;
                            n_next_step = r_next_step + 5'd1;
                        end
                    end
                end
                CMD_START: begin
                    if (!i_tgt[2] && !(r_running && r_active == i_tgt[1:0])) begin
                        n_running   = 1'b1;
                        n_active    = i_tgt[1:0];
                        n_start     = now_t;
                        n_drive     = info.level;
                        n_next_step = 5'd1;
                    end
                end
                CMD_MANUAL: begin
                    if ((!r_running || i_lvl) && i_tgt == 3'd0) begin
                        n_running = 1'b0;
                        n_drive   = i_lvl;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_active    <= '0;
            r_next_step <= '0;
            r_start     <= '0;
            r_drive     <= 1'b0;
        end else begin
            r_running   <= n_running;
            r_active    <= n_active;
            r_next_step <= n_next_step;
            r_start     <= n_start;
            r_drive     <= n_drive;
        end
    end

    // The result shows the state as it stands after this item.
    always_comb begin
        o_result.output_level   = n_drive;
        o_result.playing        = n_running;
        o_result.pattern_number = n_running ? n_active : 2'd0;
        o_result.step_index     = n_running ? n_next_step : 5'd0;
    end

    `ASSERT_CLK(a_step_in_range,
        r_running |-> (r_next_step != 5'd0) && (r_next_step <= step_count(r_active)),
        "pending step out of range while playing")
    `ASSERT_CLK(a_start_takes_effect,
        (i_accept && i_cmd == CMD_START && !i_tgt[2]) |=>
            (r_running && r_active == $past(i_tgt[1:0])),
        "valid start did not leave the pattern running")
    `ASSERT_CLK(a_manual_low_ignored,
        (i_accept && r_running && i_cmd == CMD_MANUAL && !i_lvl) |=> r_running,
        "manual low stopped playback")

endmodule

// ===== sv/tops_outbuf.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tops_outbuf
    import tops_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       pop;

    assign o_ready  = (r_count != 2'd2);
    assign o_valid  = (r_count != 2'd0);
    assign pop      = o_valid && i_ready;
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            priority if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    `ASSERT_ALWAYS(a_count_bound, !i_rst_n || (r_count <= 2'd2), "output buffer count above two")
    `ASSERT_CLK(a_no_push_when_full, i_push |-> (r_count != 2'd2),
        "result written into a full output buffer")
    `ASSERT_CLK(a_pop_drains,
        (pop && !i_push) |=> (r_count == 2'($past(r_count) - 2'd1)),
        "transfer out did not drain the buffer")

endmodule

// ===== sv/timed_output_pattern_player_core.sv =====
`timescale 1ns / 1ps

// Timed output pattern player. The block drives one on/off output from four
// built-in timed patterns of 8, 25, 18 and 12 steps, selected by a start
// command, advanced by tick commands carrying the current millisecond time,
// and overridden by manual commands. Every accepted input transfer produces
// exactly one result transfer that reports the output level, whether a pattern
// is playing, the running pattern and the next step to apply. The block takes
// one input transfer per clock cycle whenever its two-entry output buffer has
// a free entry: all decisions for an item are a single step table lookup,
// one wrapping subtraction and two compares, done in the cycle the transfer
// is accepted, and the result is registered into that buffer, so a stalled
// downstream side stops input only after two results are waiting. The unit
// number register (address 0, reset value 3) shifts the step times of
// patterns one and three, picks the levels of pattern two, and should only
// be written while no results are outstanding.
module timed_output_pattern_player_core
    import tops_pkg::*;
#(
    parameter int TIME_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // now_ms [31:0], target_index [34:32], manual_level [35], zero [39:36]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // command [1:0]
    input  logic [1:0]             s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // output_level [0], playing [1], pattern_number [3:2], step_index [8:4],
    // zero [15:9]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [1:0] r_unit_number;
    logic    in_accept;
    t_result eng_result;
    t_result buf_result;

    // Configuration port: one register, decoded on the word address bit.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_number <= 2'd3;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_UNIT_NUMBER) begin
            r_unit_number <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == REG_UNIT_NUMBER) ? {30'b0, r_unit_number} : 32'b0;

    // An input transfer completes when the output buffer has room.
    assign in_accept = s_axis_tvalid && s_axis_tready;

    tops_engine #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_cmd    (s_axis_tuser),
        .i_now_ms (s_axis_tdata[31:0]),
        .i_tgt    (s_axis_tdata[34:32]),
        .i_lvl    (s_axis_tdata[35]),
        .i_unit   (r_unit_number),
        .o_result (eng_result)
    );

    tops_outbuf u_outbuf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_result (eng_result),
        .o_ready  (s_axis_tready),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (buf_result)
    );

    assign m_axis_tdata = {7'b0, buf_result};

endmodule

// ===== tb/sv/timed_output_pattern_player_core_tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the timed output pattern player. Commands are
// streamed in over the slave stream port and every transfer is mirrored by a
// behavioral player model kept inside this module. The expected status word is
// queued and compared, field by field, against each transfer that leaves the
// master stream port. The unit number register is rewritten over the APB
// port between phases, only once the player has nothing left in flight.
module timed_output_pattern_player_core_tb;
    import tops_pkg::*;

    // Command 3 has no meaning in the block and must leave everything alone.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] UNIT_ADDR     = {REG_UNIT_NUMBER, 2'b00};
    localparam int         PATTERN_COUNT = 4;
    localparam int         HOLD_CYCLES   = 80;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         CYCLE_LIMIT   = 200_000;
    localparam int         SEGMENT_ITEMS = 45;
    localparam int         SEGMENTS      = 6;

    // One command as it travels on the input stream.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] now_ms;
        logic [2:0]  tgt;
        logic        lvl;
    } t_command;

    // One row of the directed table. Rows marked as known carry a status
    // that is obvious by inspection; all others are checked against the model.
    typedef struct packed {
        t_command cmd_item;
        logic     known;
        t_result  want;
    } t_drill_row;

    localparam logic KNOWN   = 1'b1;
    localparam logic PREDICT = 1'b0;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // now_ms [31:0], target_index [34:32], manual_level [35], zero [39:36]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // command [1:0]
    logic [1:0]             s_axis_tuser = CMD_TICK;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // output_level [0], playing [1], pattern_number [3:2], step_index [8:4],
    // zero [15:9]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [2:0]             paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Player model state, a private copy of what the block should hold.
    logic        play_on    = 1'b0;
    logic [1:0]  play_pat   = 2'd0;
    logic [4:0]  play_next  = 5'd0;
    logic [31:0] play_t0    = 32'd0;
    logic        play_level = 1'b0;
    logic [1:0]  unit_cfg   = 2'd3;

    t_result     pending_status_q [$];
    t_drill_row  drill [$];
    int          error_count   = 0;
    int          items_offered = 0;
    int          cycle_count   = 0;
    int          tx_idle_pct   = 22;
    int          rx_idle_pct   = 64;
    int          hold_asked    = 0;

    timed_output_pattern_player_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // A hung handshake or a lost result ends up here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_result pack_status(input logic lvl, input logic on,
                                            input logic [1:0] pat, input logic [4:0] step);
        t_result r;
        r.output_level   = lvl;
        r.playing        = on;
        r.pattern_number = pat;
        r.step_index     = step;
        return r;
    endfunction

    function automatic t_drill_row drill_row(input logic [1:0] cmd, input logic [31:0] now_ms,
                                             input logic [2:0] tgt, input logic lvl,
                                             input logic known, input t_result want);
        t_drill_row row;
        row.cmd_item = '{cmd: cmd, now_ms: now_ms, tgt: tgt, lvl: lvl};
        row.known    = known;
        row.want     = want;
        return row;
    endfunction

    function automatic logic [4:0] pattern_len(input logic [1:0] pat);
        logic [4:0] n;
        case (pat)
            2'd0:    n = 5'd8;
            2'd1:    n = 5'd25;
            2'd2:    n = 5'd18;
            default: n = 5'd12;
        endcase
        return n;
    endfunction

    // When step k of a pattern falls due, counted from the start command, and
    // which level it drives. Patterns one and three move with the unit number.
    function automatic void step_plan(input logic [1:0] pat, input logic [4:0] k,
                                      output logic [31:0] due_ms, output logic level);
        logic [31:0] kk;
        logic [31:0] shift;
        kk = 32'(k);
        case (pat)
            2'd0: begin
                case (k[2:0])
                    3'd0:    due_ms = 32'd0;
                    3'd1:    due_ms = 32'd100;
                    3'd2:    due_ms = 32'd500;
                    3'd3:    due_ms = 32'd1000;
                    3'd4:    due_ms = 32'd2000;
                    3'd5:    due_ms = 32'd2500;
                    3'd6:    due_ms = 32'd3500;
                    default: due_ms = 32'd5000;
                endcase
                level = ~k[0];
            end
            2'd1: begin
                due_ms = (k == 5'd0) ? 32'd0 : 32'd100 * kk + 32'd100 * 32'(unit_cfg);
                level  = k[0];
            end
            2'd2: begin
                if (k >= 5'd17) begin
                    due_ms = 32'd4000;
                    level  = 1'b0;
                end else begin
                    due_ms = 32'd200 * kk;
                    // The last two real steps are high whatever the branch.
                    if (k >= 5'd15) begin
                        level = 1'b1;
                    end else if (unit_cfg < 2'd2) begin
                        level = k[0];
                    end else begin
                        level = ~k[0];
                    end
                end
            end
            default: begin
                if (k >= 5'd11) begin
                    due_ms = 32'd4500;
                    level  = 1'b0;
                end else if (k == 5'd10) begin
                    due_ms = 32'd3000;
                    level  = 1'b1;
                end else begin
                    // Unit 1 shifts by 3, unit 2 by 1, unit 3 by 2, unit 0 not at all.
                    case (unit_cfg)
                        2'd1:    shift = 32'd300;
                        2'd2:    shift = 32'd100;
                        2'd3:    shift = 32'd200;
                        default: shift = 32'd0;
                    endcase
                    case (k[3:0])
                        4'd0:    due_ms = 32'd0;
                        4'd1:    due_ms = 32'd100;
                        4'd2:    due_ms = 32'd500;
                        4'd3:    due_ms = 32'd600;
                        4'd4:    due_ms = 32'd1100;
                        4'd5:    due_ms = 32'd1200;
                        4'd6:    due_ms = 32'd1700;
                        4'd7:    due_ms = 32'd1800;
                        4'd8:    due_ms = 32'd2300;
                        default: due_ms = 32'd2400;
                    endcase
                    due_ms = due_ms + shift;
                    level  = ~k[0];
                end
            end
        endcase
    endfunction

    // Applies one command to the player model and returns the status word the
    // block should report for it.
    function automatic t_result advance_player(input t_command c);
        logic [31:0] due_ms;
        logic [31:0] elapsed;
        logic        step_level;
        case (c.cmd)
            CMD_TICK: begin
                if (play_on) begin
                    if (play_next >= pattern_len(play_pat)) begin
                        // Every step has been played: stop and force the output low.
                        play_on    = 1'b0;
                        play_level = 1'b0;
                    end else begin
                        step_plan(play_pat, play_next, due_ms, step_level);
                        // The subtraction wraps, so a start just before the
                        // timer rolls over still measures correctly.
                        elapsed = c.now_ms - play_t0;
                        if (elapsed >= due_ms) begin
                            play_level = step_level;
                            play_next  = play_next + 5'd1;
                        end
                    end
                end
            end
            CMD_START: begin
                // A bad pattern number or a restart of the running one is ignored.
                if (c.tgt < 3'(PATTERN_COUNT) && !(play_on && play_pat == c.tgt[1:0])) begin
                    play_on  = 1'b1;
                    play_pat = c.tgt[1:0];
                    play_t0  = c.now_ms;
                    step_plan(play_pat, 5'd0, due_ms, step_level);
                    play_level = step_level;
                    play_next  = 5'd1;
                end
            end
            CMD_MANUAL: begin
                // Only output 0 exists; a low request cannot interrupt playback.
                if ((!play_on || c.lvl) && c.tgt == 3'd0) begin
                    play_on    = 1'b0;
                    play_level = c.lvl;
                end
            end
            default: ;
        endcase
        return pack_status(play_level, play_on, play_on ? play_pat : 2'd0,
                           play_on ? play_next : 5'd0);
    endfunction

    function automatic void check_result(input logic [OUT_TDATA_W-1:0] tdata);
        t_result got;
        t_result want;
        got = tdata[$bits(t_result)-1:0];
        if (pending_status_q.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual %h", $time, tdata);
            error_count++;
            return;
        end
        want = pending_status_q.pop_front();
        if (got.output_level !== want.output_level) begin
            $display("%0t: output_level expected %0d actual %0d",
                     $time, want.output_level, got.output_level);
            error_count++;
        end
        if (got.playing !== want.playing) begin
            $display("%0t: playing expected %0d actual %0d", $time, want.playing, got.playing);
            error_count++;
        end
        if (got.pattern_number !== want.pattern_number) begin
            $display("%0t: pattern_number expected %0d actual %0d",
                     $time, want.pattern_number, got.pattern_number);
            error_count++;
        end
        if (got.step_index !== want.step_index) begin
            $display("%0t: step_index expected %0d actual %0d",
                     $time, want.step_index, got.step_index);
            error_count++;
        end
        if (tdata[OUT_TDATA_W-1:$bits(t_result)] !== '0) begin
            $display("%0t: tdata padding expected 0 actual %h",
                     $time, tdata[OUT_TDATA_W-1:$bits(t_result)]);
            error_count++;
        end
    endfunction

    // Result side. Ready is redrawn every cycle from the current idle rate,
    // except during a requested hold-off, which this process counts out itself
    // so that the sender keeps pushing and the block's buffer fills up.
    always @(posedge i_clk) begin
        int hold_left;
        int hold_seen;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_result(m_axis_tdata);
            end
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Offers one command, possibly after a random gap, and queues the status
    // expected for it at the edge where the transfer completes. Entered and
    // left right after a rising edge.
    task automatic offer(input t_command c, input logic known, input t_result want);
        t_result predicted;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c.cmd;
        s_axis_tdata  <= {{(IN_TDATA_W - 36){1'b0}}, c.lvl, c.tgt, c.now_ms};
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = advance_player(c);
        pending_status_q.push_back(known ? want : predicted);
        items_offered++;
    endtask

    // Stops offering and waits until every queued status has been checked.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_status_q.size() != 0) @(posedge i_clk);
    endtask

    // Writes the unit number while the block is idle and reads it back.
    task automatic write_unit(input logic [1:0] value);
        logic [31:0] readback;
        drain_results();
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= UNIT_ADDR;
        pwdata  <= {30'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        unit_cfg = value;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {30'd0, value}) begin
            $display("%0t: unit_number readback expected %h actual %h",
                     $time, {30'd0, value}, readback);
            error_count++;
        end
    endtask

    function automatic t_command random_command();
        t_command c;
        c.cmd    = 2'($urandom_range(0, 3));
        c.now_ms = $urandom();
        // Output 0 is the only real output, so favor it to reach manual sets.
        c.tgt    = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(0, 7));
        c.lvl    = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // One well-formed run: a start, then ticks with the time moving forward
    // by random amounts until the pattern ends, with the odd stray command
    // mixed in (manual sets, restarts, unused codes).
    task automatic run_pattern_sequence();
        t_command c;
        logic [31:0] clock_ms;
        int ticks;
        clock_ms = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 3000)
                                               : $urandom();
        c = '{cmd: CMD_START, now_ms: clock_ms, tgt: 3'($urandom_range(0, 3)),
              lvl: 1'($urandom_range(0, 1))};
        offer(c, PREDICT, '0);
        ticks = 0;
        while (play_on && ticks < 60) begin
            if ($urandom_range(0, 99) < 8) begin
                offer(random_command(), PREDICT, '0);
            end else begin
                clock_ms = clock_ms + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 20)
                                                                   : $urandom_range(0, 350));
                c = '{cmd: CMD_TICK, now_ms: clock_ms, tgt: 3'($urandom_range(0, 7)),
                      lvl: 1'($urandom_range(0, 1))};
                offer(c, PREDICT, '0);
            end
            ticks++;
        end
    endtask

    // A random phase of roughly the given number of commands. With squeeze
    // set, the result side is held off right at the start while the sender
    // keeps offering, and about twenty commands later the sender waits until
    // the block has caught up.
    task automatic play_segment(input int quota, input bit squeeze);
        int goal;
        int mid;
        bit held;
        bit paused;
        goal   = items_offered + quota;
        mid    = items_offered;
        held   = 1'b0;
        paused = 1'b0;
        while (items_offered < goal) begin
            if (squeeze && !held && items_offered >= mid) begin
                hold_asked <= hold_asked + 1;
                held = 1'b1;
            end
            if (squeeze && !paused && items_offered >= mid + 20) begin
                drain_results();
                paused = 1'b1;
            end
            if ($urandom_range(0, 99) < 75) begin
                run_pattern_sequence();
            end else begin
                repeat ($urandom_range(1, 4)) offer(random_command(), PREDICT, '0);
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with the unit number left at its reset value 3.
        drill.push_back(drill_row(CMD_TICK, 32'h0000_0000, 3'd0, 1'b0, KNOWN,
                                  pack_status(1'b0, 1'b0, 2'd0, 5'd0)));
        // Manual set of output 0 while idle takes either level.
        drill.push_back(drill_row(CMD_MANUAL, 32'h0000_0001, 3'd0, 1'b1, KNOWN,
                                  pack_status(1'b1, 1'b0, 2'd0, 5'd0)));
        drill.push_back(drill_row(CMD_MANUAL, 32'h0000_0002, 3'd0, 1'b0, KNOWN,
                                  pack_status(1'b0, 1'b0, 2'd0, 5'd0)));
        // A manual command for a missing output does nothing.
        drill.push_back(drill_row(CMD_MANUAL, 32'h0000_0003, 3'd7, 1'b1, KNOWN,
                                  pack_status(1'b0, 1'b0, 2'd0, 5'd0)));
        drill.push_back(drill_row(CMD_UNUSED, 32'hFFFF_FFFF, 3'd7, 1'b1, KNOWN,
                                  pack_status(1'b0, 1'b0, 2'd0, 5'd0)));
        // Start of a pattern number that does not exist.
        drill.push_back(drill_row(CMD_START, 32'h0000_0004, 3'd4, 1'b0, KNOWN,
                                  pack_status(1'b0, 1'b0, 2'd0, 5'd0)));
        // Start just before the timer wraps; step 0 is high right away.
        drill.push_back(drill_row(CMD_START, 32'hFFFF_FF00, 3'd0, 1'b0, KNOWN,
                                  pack_status(1'b1, 1'b1, 2'd0, 5'd1)));
        // Restarting the running pattern is ignored and keeps the old start time.
        drill.push_back(drill_row(CMD_START, 32'h0000_0000, 3'd0, 1'b1, KNOWN,
                                  pack_status(1'b1, 1'b1, 2'd0, 5'd1)));
        // One millisecond short of step 1, then exactly on it.
        drill.push_back(drill_row(CMD_TICK, 32'hFFFF_FF63, 3'd0, 1'b0, PREDICT, '0));
        drill.push_back(drill_row(CMD_TICK, 32'hFFFF_FF64, 3'd0, 1'b0, PREDICT, '0));
        // Manual low during playback is ignored, as is any manual to output 1.
        drill.push_back(drill_row(CMD_MANUAL, 32'hFFFF_FF65, 3'd0, 1'b0, PREDICT, '0));
        drill.push_back(drill_row(CMD_MANUAL, 32'hFFFF_FF66, 3'd1, 1'b1, PREDICT, '0));
        // The timer has wrapped past zero; elapsed time is still 512 ms.
        drill.push_back(drill_row(CMD_TICK, 32'h0000_0100, 3'd0, 1'b0, PREDICT, '0));
        // Manual high wins over playback and stops it.
        drill.push_back(drill_row(CMD_MANUAL, 32'h0000_0101, 3'd0, 1'b1, KNOWN,
                                  pack_status(1'b1, 1'b0, 2'd0, 5'd0)));
        // Switching straight from one pattern to another.
        drill.push_back(drill_row(CMD_START, 32'h0000_0000, 3'd3, 1'b0, PREDICT, '0));
        drill.push_back(drill_row(CMD_START, 32'h0000_0000, 3'd1, 1'b0, PREDICT, '0));
        drill.push_back(drill_row(CMD_START, 32'hFFFF_FFFF, 3'd2, 1'b0, PREDICT, '0));
        // Pattern 0 played to its end: one step per tick, then the stopping tick.
        drill.push_back(drill_row(CMD_START, 32'h0000_0000, 3'd0, 1'b0, PREDICT, '0));
        repeat (7) drill.push_back(drill_row(CMD_TICK, 32'd5000, 3'd0, 1'b0, PREDICT, '0));
        drill.push_back(drill_row(CMD_TICK, 32'd5000, 3'd0, 1'b0, KNOWN,
                                  pack_status(1'b0, 1'b0, 2'd0, 5'd0)));

        foreach (drill[i]) offer(drill[i].cmd_item, drill[i].known, drill[i].want);

        // Random phases. The unit number walks through 0, 3, 2, 1, 0, 3 and
        // the idle rates go sender-light, then receiver-light, then none.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            write_unit(2'((seg * 3) % 4));
            if (seg < 2) begin
                tx_idle_pct = 22;
                rx_idle_pct = 64;
            end else if (seg < 4) begin
                tx_idle_pct = 64;
                rx_idle_pct = 22;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            play_segment(SEGMENT_ITEMS, seg == 0 || seg == 3);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_status_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tops_pkg.sv
sv/tops_engine.sv
sv/tops_outbuf.sv
sv/timed_output_pattern_player_core.sv
tb/sv/timed_output_pattern_player_core_tb.sv
